// ----- design/hpcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpcc_pkg
// Widths and constants shared by the hue-preserving color clamp.
// ----------------------------------------------------------------------------
package hpcc_pkg;

  // Fixed-point format: FRAC_BITS fraction bits, so 1.0 is 1 << FRAC_BITS.
  localparam int FRAC_BITS = 12;
  localparam int IN_W      = 18;
  localparam int OUT_W     = 14;

  // Chroma and the difference magnitudes span the whole input range.
  localparam int CH_W      = IN_W;
  // Quotient magnitude lies in 0..1.0, which needs one bit more than the fraction.
  localparam int Q_W       = FRAC_BITS + 1;
  // One divider stage per quotient bit.
  localparam int DIV_STG   = Q_W;
  // Hue spans 0..6.0: three integer bits, the fraction, and a sign bit.
  localparam int HUE_W     = FRAC_BITS + 4;
  localparam int PROD_W    = 2 * Q_W;

  localparam logic [Q_W-1:0] ONE = Q_W'(1) << FRAC_BITS;

  // Hue sector bases for the three choices of smallest component.
  localparam logic [2:0] BASE_RED_MIN   = 3'd3;
  localparam logic [2:0] BASE_GREEN_MIN = 3'd5;
  localparam logic [2:0] BASE_BLUE_MIN  = 3'd1;

  typedef logic signed [IN_W-1:0]  comp_in_t;
  typedef logic signed [OUT_W-1:0] comp_out_t;

endpackage

// ----- design/hpcc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpcc_in_if / hpcc_out_if
// Valid/ready channels that carry one pixel in and one rebuilt pixel out.
// ----------------------------------------------------------------------------
interface hpcc_in_if;
  logic                       valid;
  logic                       ready;
  hpcc_pkg::comp_in_t         red_in;
  hpcc_pkg::comp_in_t         green_in;
  hpcc_pkg::comp_in_t         blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface hpcc_out_if;
  logic                       valid;
  logic                       ready;
  hpcc_pkg::comp_out_t        red_out;
  hpcc_pkg::comp_out_t        green_out;
  hpcc_pkg::comp_out_t        blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

// ----- design/hue_preserving_color_clamp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hue_preserving_color_clamp
// Clamps value and chroma of an RGB pixel to 0..1.0 while keeping its hue.
// ----------------------------------------------------------------------------
// Usage:
//   in_pix carries one signed Q5.12 pixel per transfer; out_pix returns one
//   rebuilt signed Q12 pixel per transfer, in the same order.
//   One stage finds max, min and chroma, one restoring-division stage per
//   quotient bit forms the hue fraction, then hue/sector, product and output
//   stages follow. Throughput is one pixel per cycle while the receiver takes
//   its results; the whole pipe advances together.
//   When the receiver stalls with a result waiting, every stage holds and
//   in_pix.ready drops; no pixel is lost or repeated. Bubbles are not
//   squeezed out: a stall freezes every stage, empty or not, and the pipe
//   only moves while the output stage is empty or its result is taken.
//   A synchronous active-low reset clears all valid bits; payload registers
//   are not reset. There is no configuration and no state between pixels.
// ----------------------------------------------------------------------------
module hue_preserving_color_clamp (
  input  logic         clk,
  input  logic         rst_n,
  hpcc_in_if.sink      in_pix,
  hpcc_out_if.source   out_pix
);
  import hpcc_pkg::*;

  logic adv;

  // Stage A: extremes, chroma and signed difference.
  logic               a_vld_r;
  logic [CH_W-1:0]    a_c_r;
  logic [CH_W-1:0]    a_dabs_r;
  logic               a_dneg_r;
  logic [2:0]         a_base_r;
  logic               a_grey_r;
  logic [Q_W-1:0]     a_v_r;
  logic [Q_W-1:0]     a_s_r;

  // Divider stages.
  logic               dv_vld_r  [DIV_STG];
  logic [CH_W:0]      dv_rem_r  [DIV_STG];
  logic [Q_W-1:0]     dv_q_r    [DIV_STG];
  logic [CH_W-1:0]    dv_c_r    [DIV_STG];
  logic               dv_dneg_r [DIV_STG];
  logic [2:0]         dv_base_r [DIV_STG];
  logic               dv_grey_r [DIV_STG];
  logic [Q_W-1:0]     dv_v_r    [DIV_STG];
  logic [Q_W-1:0]     dv_s_r    [DIV_STG];
  logic [CH_W:0]      dv_rem_nxt [DIV_STG];
  logic [Q_W-1:0]     dv_q_nxt   [DIV_STG];

  // Stage H: sector and adjusted fraction.
  logic               h_vld_r;
  logic [2:0]         h_sector_r;
  logic [Q_W-1:0]     h_frac_r;
  logic [Q_W-1:0]     h_v_r;
  logic [Q_W-1:0]     h_s_r;

  // Stage P: fraction times chroma.
  logic               p_vld_r;
  logic [2:0]         p_sector_r;
  logic [PROD_W-1:0]  p_prod_r;
  logic [Q_W-1:0]     p_v_r;
  logic [Q_W-1:0]     p_s_r;

  // Output stage.
  logic               o_vld_r;
  comp_out_t          o_red_r;
  comp_out_t          o_green_r;
  comp_out_t          o_blue_r;

  // The whole pipe moves unless a finished result is held by the receiver.
  assign adv          = !o_vld_r || out_pix.ready;
  assign in_pix.ready = adv;

  // Stage A logic.
  logic signed [IN_W:0] r_x, g_x, b_x, mx_x, mn_x, d_x, c_x;
  logic [CH_W-1:0]      c_nxt, dabs_nxt;
  logic                 dneg_nxt, grey_nxt;
  logic [2:0]           base_nxt;
  logic [Q_W-1:0]       v_nxt, s_nxt;

  always_comb begin
    g_x = (IN_W+1)'(in_pix.green_in);
    b_x = (IN_W+1)'(in_pix.blue_in);
    r_x = (IN_W+1)'(in_pix.red_in);
    if (r_x >= g_x && r_x >= b_x)      mx_x = r_x;
    else if (g_x >= r_x && g_x >= b_x) mx_x = g_x;
    else                               mx_x = b_x;
    if (r_x <= g_x && r_x <= b_x)      mn_x = r_x;
    else if (g_x <= r_x && g_x <= b_x) mn_x = g_x;
    else                               mn_x = b_x;
    c_x = mx_x - mn_x;
    if (r_x == mn_x) begin
      d_x = g_x - b_x;  base_nxt = BASE_RED_MIN;
    end else if (g_x == mn_x) begin
      d_x = b_x - r_x;  base_nxt = BASE_GREEN_MIN;
    end else begin
      d_x = r_x - g_x;  base_nxt = BASE_BLUE_MIN;
    end
    grey_nxt = (c_x == '0);
    // A grey pixel divides zero by one so the quotient comes out zero.
    c_nxt    = grey_nxt ? CH_W'(1) : c_x[CH_W-1:0];
    dneg_nxt = d_x[IN_W];
    dabs_nxt = dneg_nxt ? CH_W'(-d_x) : d_x[CH_W-1:0];
    if (grey_nxt) dabs_nxt = '0;
    // Clamp value and chroma to 0..1.0.
    if (mx_x[IN_W])                          v_nxt = '0;
    else if (mx_x > (IN_W+1)'(ONE))          v_nxt = ONE;
    else                                     v_nxt = mx_x[Q_W-1:0];
    if (c_x > (IN_W+1)'(ONE))                s_nxt = ONE;
    else                                     s_nxt = c_x[Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_pix.valid;
    end
    if (adv) begin
      a_c_r    <= c_nxt;
      a_dabs_r <= dabs_nxt;
      a_dneg_r <= dneg_nxt;
      a_base_r <= base_nxt;
      a_grey_r <= grey_nxt;
      a_v_r    <= v_nxt;
      a_s_r    <= s_nxt;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  always_comb begin
    logic [CH_W:0]   rem_in;
    logic [CH_W:0]   trial;
    logic [Q_W-1:0]  q_in;
    logic [CH_W-1:0] c_in;
    logic            ge;
    for (int k = 0; k < DIV_STG; k++) begin
      if (k == 0) begin
        rem_in = {1'b0, a_dabs_r};
        q_in   = '0;
        c_in   = a_c_r;
        trial  = rem_in;
      end else begin
        rem_in = dv_rem_r[k-1];
        q_in   = dv_q_r[k-1];
        c_in   = dv_c_r[k-1];
        trial  = {rem_in[CH_W-1:0], 1'b0};
      end
      ge            = (trial >= {1'b0, c_in});
      dv_rem_nxt[k] = ge ? trial - {1'b0, c_in} : trial;
      dv_q_nxt[k]   = {q_in[Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STG; k++) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[k] <= (k == 0) ? a_vld_r : dv_vld_r[k == 0 ? 0 : k-1];
      end
      if (adv) begin
        dv_rem_r[k] <= dv_rem_nxt[k];
        dv_q_r[k]   <= dv_q_nxt[k];
        if (k == 0) begin
          dv_c_r[k]    <= a_c_r;
          dv_dneg_r[k] <= a_dneg_r;
          dv_base_r[k] <= a_base_r;
          dv_grey_r[k] <= a_grey_r;
          dv_v_r[k]    <= a_v_r;
          dv_s_r[k]    <= a_s_r;
        end else begin
          dv_c_r[k]    <= dv_c_r[k-1];
          dv_dneg_r[k] <= dv_dneg_r[k-1];
          dv_base_r[k] <= dv_base_r[k-1];
          dv_grey_r[k] <= dv_grey_r[k-1];
          dv_v_r[k]    <= dv_v_r[k-1];
          dv_s_r[k]    <= dv_s_r[k-1];
        end
      end
    end
  end

  // Hue from base and signed quotient, then the sector and its fraction.
  logic [HUE_W-1:0] hue;
  logic [Q_W-1:0]   qfin;
  logic [Q_W-1:0]   frac_nxt;
  logic [2:0]       sector_nxt;

  always_comb begin
    qfin = dv_q_r[DIV_STG-1];
    if (dv_grey_r[DIV_STG-1]) begin
      hue = '0;
    end else if (dv_dneg_r[DIV_STG-1]) begin
      hue = {1'b0, dv_base_r[DIV_STG-1], FRAC_BITS'(0)} + HUE_W'(qfin);
    end else begin
      hue = {1'b0, dv_base_r[DIV_STG-1], FRAC_BITS'(0)} - HUE_W'(qfin);
    end
    sector_nxt = hue[FRAC_BITS +: 3];
    frac_nxt   = {1'b0, hue[FRAC_BITS-1:0]};
    if (!sector_nxt[0]) frac_nxt = ONE - frac_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
      p_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (adv) begin
      h_vld_r <= dv_vld_r[DIV_STG-1];
      p_vld_r <= h_vld_r;
      o_vld_r <= p_vld_r;
    end
    if (adv) begin
      h_sector_r <= sector_nxt;
      h_frac_r   <= frac_nxt;
      h_v_r      <= dv_v_r[DIV_STG-1];
      h_s_r      <= dv_s_r[DIV_STG-1];
      p_sector_r <= h_sector_r;
      p_prod_r   <= PROD_W'(h_frac_r) * PROD_W'(h_s_r);
      p_v_r      <= h_v_r;
      p_s_r      <= h_s_r;
    end
  end

  // Rebuild the color from V, N and M by sector.
  comp_out_t vv, nn, mm;
  comp_out_t red_nxt, green_nxt, blue_nxt;

  always_comb begin
    vv = OUT_W'(p_v_r);
    mm = OUT_W'(p_v_r) - OUT_W'(p_s_r);
    nn = OUT_W'(p_v_r) - OUT_W'(p_prod_r[PROD_W-1:FRAC_BITS]);
    case (p_sector_r)
      3'd1:    begin red_nxt = nn; green_nxt = vv; blue_nxt = mm; end
      3'd2:    begin red_nxt = mm; green_nxt = vv; blue_nxt = nn; end
      3'd3:    begin red_nxt = mm; green_nxt = nn; blue_nxt = vv; end
      3'd4:    begin red_nxt = nn; green_nxt = mm; blue_nxt = vv; end
      3'd5:    begin red_nxt = vv; green_nxt = mm; blue_nxt = nn; end
      default: begin red_nxt = vv; green_nxt = nn; blue_nxt = mm; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_red_r   <= red_nxt;
      o_green_r <= green_nxt;
      o_blue_r  <= blue_nxt;
    end
  end

  assign out_pix.valid     = o_vld_r;
  assign out_pix.red_out   = o_red_r;
  assign out_pix.green_out = o_green_r;
  assign out_pix.blue_out  = o_blue_r;

  // The quotient never exceeds 1.0 because the difference never exceeds chroma.
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld_r[DIV_STG-1] |-> dv_q_r[DIV_STG-1] <= ONE)
    else $error("divider quotient above 1.0");

  // The hue lies in 0..6, so the sector never exceeds six.
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    h_vld_r |-> h_sector_r <= 3'd6)
    else $error("hue sector out of range");

  // The pipe stalls only while a result waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> o_vld_r && !out_pix.ready)
    else $error("input stalled without a blocked output");

  // A held result stays put until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r && !out_pix.ready |=> o_vld_r && $stable(o_red_r) &&
      $stable(o_green_r) && $stable(o_blue_r))
    else $error("stalled result changed");

endmodule

// ----- test/hpcc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpcc_checker
// Watches both pixel channels. Each input transfer queues the clamped pixel
// it should produce, and each output transfer is compared with the oldest one.
// ----------------------------------------------------------------------------
module hpcc_checker (
  input  logic      clk,
  input  logic      rst_n,
  hpcc_in_if.sink   in_mon,
  hpcc_out_if.sink  out_mon,
  output int        fail_count,
  output int        pending
);
  import hpcc_pkg::*;

  typedef struct packed {
    comp_out_t red;
    comp_out_t green;
    comp_out_t blue;
  } pixel_out_t;

  pixel_out_t clamped_q[$];

  assign pending = clamped_q.size();

  // Rebuilds the pixel at the same hue with value and chroma held to 0..1.0.
  function automatic pixel_out_t clamp_pixel(comp_in_t r_i, comp_in_t g_i, comp_in_t b_i);
    longint r, g, b, mx, mn, c, hue, fr, v, s, m, n, one;
    longint o0, o1, o2;
    int sec;
    pixel_out_t p;
    one = 64'sd1 <<< FRAC_BITS;
    r = r_i;
    g = g_i;
    b = b_i;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    c = mx - mn;
    // The smallest component picks the sector base; red wins a tie, then green.
    if (c == 0) hue = 0;
    else if (r == mn) hue = 3 * one - ((g - b) * one) / c;
    else if (g == mn) hue = 5 * one - ((b - r) * one) / c;
    else hue = one - ((r - g) * one) / c;
    sec = int'(hue >>> FRAC_BITS);
    fr = hue & (one - 1);
    if (sec % 2 == 0) fr = one - fr;
    v = (mx > one) ? one : ((mx < 0) ? 0 : mx);
    s = (c > one) ? one : c;
    m = v - s;
    n = v - ((fr * s) >>> FRAC_BITS);
    case (sec)
      1: begin o0 = n; o1 = v; o2 = m; end
      2: begin o0 = m; o1 = v; o2 = n; end
      3: begin o0 = m; o1 = n; o2 = v; end
      4: begin o0 = n; o1 = m; o2 = v; end
      5: begin o0 = v; o1 = m; o2 = n; end
      default: begin o0 = v; o1 = n; o2 = m; end
    endcase
    p.red   = comp_out_t'(o0);
    p.green = comp_out_t'(o1);
    p.blue  = comp_out_t'(o2);
    return p;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  // Input transfers queue predictions; output transfers are checked in order.
  always @(posedge clk) begin
    pixel_out_t w;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        clamped_q.push_back(clamp_pixel(in_mon.red_in, in_mon.green_in, in_mon.blue_in));
      if (out_mon.valid && out_mon.ready) begin
        if (clamped_q.size() == 0) begin
          report("unexpected transfer", 0, 0);
        end else begin
          w = clamped_q.pop_front();
          if (out_mon.red_out !== w.red) report("red", out_mon.red_out, w.red);
          if (out_mon.green_out !== w.green) report("green", out_mon.green_out, w.green);
          if (out_mon.blue_out !== w.blue) report("blue", out_mon.blue_out, w.blue);
        end
      end
    end
  end
endmodule

// ----- test/hue_preserving_color_clamp_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hue_preserving_color_clamp_test
// Drives directed and random pixels with random gaps and stalls into the
// clamp; a checker beside it predicts and compares every output pixel.
// ----------------------------------------------------------------------------
module hue_preserving_color_clamp_test;
  import hpcc_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int N_RANDOM   = 1600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending;
  int   idle_cycles = 0;
  bit   long_hold = 1'b0;
  bit   sending_done = 1'b0;

  hpcc_in_if  in_pix();
  hpcc_out_if out_pix();

  always #5 clk = ~clk;

  hue_preserving_color_clamp dut (.clk(clk), .rst_n(rst_n), .in_pix(in_pix), .out_pix(out_pix));
  hpcc_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_pix), .out_mon(out_pix),
                    .fail_count(fail_count), .pending(pending));

  // Sends one pixel after a random gap and waits for its transfer.
  // Valid drops only for a gap, so back-to-back pixels keep it high.
  task automatic send_pixel(comp_in_t r, comp_in_t g, comp_in_t b);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7));
    if (gap > 0) begin
      in_pix.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_pix.valid    <= 1'b1;
    in_pix.red_in   <= r;
    in_pix.green_in <= g;
    in_pix.blue_in  <= b;
    do @(posedge clk); while (!in_pix.ready);
    @(negedge clk);
  endtask

  // Stops offering pixels and waits until every expected result has come.
  task automatic drain();
    in_pix.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  function automatic comp_in_t pick_comp();
    case ($urandom_range(0, 5))
      0: return comp_in_t'($urandom);
      1: return comp_in_t'($urandom_range(0, 8192)) - comp_in_t'(2048);
      2: return comp_in_t'($urandom_range(0, 4096));
      3: return comp_in_t'($urandom_range(0, 12)) - comp_in_t'(6);
      4: return ($urandom_range(0, 1)) ? comp_in_t'(18'sh1ffff) : comp_in_t'(18'sh20000);
      default: return comp_in_t'($urandom_range(0, 20000));
    endcase
  endfunction

  // Receiver: random stalls, with one long hold-off to fill the pipe.
  initial begin
    int stall;
    out_pix.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_pix.ready <= 1'b0;
        repeat (60) @(negedge clk);
        long_hold = 1'b0;
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_pix.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
        @(negedge clk);
      end
      out_pix.ready <= 1'b1;
      do @(negedge clk); while (!(out_pix.valid && out_pix.ready) && $urandom_range(0, 3) != 0);
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_pix.valid && in_pix.ready) || (out_pix.valid && out_pix.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    comp_in_t r, g, b;
    in_pix.valid = 1'b0;
    in_pix.red_in = '0;
    in_pix.green_in = '0;
    in_pix.blue_in = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: grey, extremes, each minimum, ties and each sector.
    send_pixel(0, 0, 0);
    send_pixel(4096, 4096, 4096);
    send_pixel(-131072, -131072, -131072);
    send_pixel(131071, 131071, 131071);
    send_pixel(131071, -131072, 0);
    send_pixel(-131072, 131071, 131071);
    send_pixel(131071, 131071, -131072);
    send_pixel(4096, 0, 0);
    send_pixel(4096, 4096, 0);
    send_pixel(0, 4096, 0);
    send_pixel(0, 4096, 4096);
    send_pixel(0, 0, 4096);
    send_pixel(4096, 0, 4096);
    send_pixel(4096, 1, 0);
    send_pixel(4096, 0, 1);
    send_pixel(0, 1, 4096);
    send_pixel(-100, 200, 50);
    send_pixel(100, -4000, 3000);
    send_pixel(2048, 1024, 3072);
    send_pixel(-1, 1, 0);
    send_pixel(9000, 8000, 7000);

    // Let everything drain before the random part.
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 400) long_hold = 1'b1;
      if (i == 800) drain();
      r = pick_comp();
      g = ($urandom_range(0, 7) == 0) ? r : pick_comp();
      b = ($urandom_range(0, 7) == 0) ? g : pick_comp();
      send_pixel(r, g, b);
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
